// ===== rtl/core/extended_rtc_millisecond_clock_macros.svh =====
// Assertion shorthands for the millisecond clock.
// Each one samples on clk and is switched off while rst_n is low.
`ifndef EXTENDED_RTC_MILLISECOND_CLOCK_MACROS_SVH
`define EXTENDED_RTC_MILLISECOND_CLOCK_MACROS_SVH

// Same-cycle implication.
`define RTCMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RTCMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rtcms_pkg.sv =====
package rtcms_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned PROD_W   = 42;   // 32-bit count times a 10-bit constant
  localparam int unsigned TICK_SHIFT = 15; // 32768 Hz ticks
  localparam int unsigned HI_SHIFT   = SAMPLE_W - TICK_SHIFT;

  localparam logic [9:0] MS_PER_SEC = 10'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_REFRESH   = 3'd0,
    CMD_READ      = 3'd1,
    CMD_READ_PRES = 3'd2,
    CMD_SET       = 3'd3,
    CMD_DISABLE   = 3'd4,
    CMD_RESTORE   = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   new_time;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic              clock_enabled;
  } res_t;

endpackage

// ===== rtl/core/extended_rtc_millisecond_clock.sv =====
// Millisecond clock on top of a free-running 32768 Hz counter.
// Input channel (in_valid/in_ready): a command, a 32-bit counter sample and
// a 64-bit base time. Result channel (out_valid/out_ready): the time in
// milliseconds and the enable flag after the command. Every input transfer
// yields exactly one result transfer, in order.
// Path: an accepted item waits in the input register and moves into the result
// register once that is free; out_valid rises when the result lands there.
// Throughput: one item per cycle while out_ready stays high; the single pass
// through the state logic (constant multiplies by 1000 and 64-bit adds)
// updates the clock state in the same cycle that the item leaves the input
// register.
// Reset (rst_n low, synchronous): the clock is disabled, base, high word
// and last sample are cleared, and both pipeline registers are emptied.
// Stall: while out_ready is low the result register holds its transfer, one
// more item may wait in the input register, and in_ready drops once both
// are full. Nothing is lost or repeated across a stall.
`include "extended_rtc_millisecond_clock_macros.svh"

module extended_rtc_millisecond_clock (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rtcms_pkg::CMD_W-1:0]    in_cmd,
  input  logic [rtcms_pkg::SAMPLE_W-1:0] in_counter_sample,
  input  logic [rtcms_pkg::TIME_W-1:0]   in_new_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rtcms_pkg::TIME_W-1:0]   out_time_ms,
  output logic                          out_clock_enabled
);
  import rtcms_pkg::*;

  // Input register stage.
  logic  s1_valid_r, s1_valid_nxt;
  item_t s1_item_r;

  // Result register stage.
  logic  out_valid_r, out_valid_nxt;
  res_t  out_res_r;

  logic  out_free;
  logic  fire;
  logic  in_xfer;
  res_t  res;

  // The result register can take a new transfer when empty or draining.
  assign out_free = !out_valid_r || out_ready;
  // Advance the input register into the state logic.
  assign fire     = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_xfer  = in_valid && in_ready;

  rtcms_state u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .res   (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.cmd      <= in_cmd;
      s1_item_r.sample   <= in_counter_sample;
      s1_item_r.new_time <= in_new_time;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_time_ms       = out_res_r.time_ms;
  assign out_clock_enabled = out_res_r.clock_enabled;

  `RTCMS_ASSERT_NOW(a_empty_takes, !s1_valid_r, in_ready, "input stage empty but not ready")
  `RTCMS_ASSERT_NOW(a_no_overrun, s1_valid_r && out_valid_r && !out_ready, !in_ready,
                    "input stage would be overwritten")
  `RTCMS_ASSERT_NEXT(a_xfer_lands, in_xfer, s1_valid_r, "accepted item not held")
  `RTCMS_ASSERT_NEXT(a_fire_lands, fire, out_valid_r, "processed item produced no result")
  `RTCMS_ASSERT_NOW(a_disabled_time, out_valid_r && !out_res_r.clock_enabled,
                    out_res_r.time_ms == '0 || out_res_r.time_ms == '1,
                    "disabled clock returned a real time")

endmodule

// ===== rtl/core/rtcms_ms_calc.sv =====
module rtcms_ms_calc (
  input  logic [rtcms_pkg::SAMPLE_W-1:0] hi,
  input  logic [rtcms_pkg::SAMPLE_W-1:0] lo,
  input  logic [rtcms_pkg::TIME_W-1:0]   base,
  output logic [rtcms_pkg::TIME_W-1:0]   time_ms
);
  import rtcms_pkg::*;

  logic [PROD_W-1:0] hi_prod;
  logic [PROD_W-1:0] lo_prod;
  logic [TIME_W-1:0] hi_part;
  logic [TIME_W-1:0] lo_part;

  // (hi:lo)*1000 >> 15 splits exactly: the high word lands 17 bits up.
  assign hi_prod = PROD_W'(hi) * PROD_W'(MS_PER_SEC);
  assign lo_prod = PROD_W'(lo) * PROD_W'(MS_PER_SEC);
  assign hi_part = TIME_W'(hi_prod) << HI_SHIFT;
  assign lo_part = TIME_W'(lo_prod >> TICK_SHIFT);
  assign time_ms = hi_part + lo_part + base;

endmodule

// ===== rtl/core/rtcms_state.sv =====
module rtcms_state (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  rtcms_pkg::item_t item,
  output rtcms_pkg::res_t  res
);
  import rtcms_pkg::*;

  logic                enabled_r, enabled_nxt;
  logic [TIME_W-1:0]   base_r, base_nxt;
  logic [SAMPLE_W-1:0] high_r, high_nxt;
  logic [SAMPLE_W-1:0] last_r, last_nxt;

  cmd_t                cmd;
  logic [SAMPLE_W-1:0] samp_hi;
  logic                use_samp;
  logic [SAMPLE_W-1:0] calc_hi;
  logic [SAMPLE_W-1:0] calc_lo;
  logic [TIME_W-1:0]   calc_time;
  logic [TIME_W-1:0]   cur_time;

  assign cmd     = cmd_t'(item.cmd);
  // Extend the sample: a wrap shows up as a reading below the last one.
  assign samp_hi = (item.sample < last_r) ? high_r + SAMPLE_W'(1) : high_r;

  assign use_samp = enabled_r && (cmd == CMD_READ);
  assign calc_hi  = use_samp ? samp_hi : high_r;
  assign calc_lo  = use_samp ? item.sample : last_r;

  rtcms_ms_calc u_calc (
    .hi      (calc_hi),
    .lo      (calc_lo),
    .base    (base_r),
    .time_ms (calc_time)
  );

  assign cur_time = enabled_r ? calc_time : '1;

  always_comb begin
    enabled_nxt = enabled_r;
    base_nxt    = base_r;
    high_nxt    = high_r;
    last_nxt    = last_r;
    case (cmd)
      CMD_REFRESH, CMD_READ: begin
        if (enabled_r) begin
          high_nxt = samp_hi;
          last_nxt = item.sample;
        end
      end
      CMD_SET: begin
        base_nxt    = item.new_time;
        high_nxt    = '0;
        last_nxt    = '0;
        enabled_nxt = 1'b1;
      end
      CMD_DISABLE: begin
        enabled_nxt = 1'b0;
      end
      CMD_RESTORE: begin
        base_nxt    = cur_time;
        high_nxt    = '0;
        last_nxt    = '0;
        enabled_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.clock_enabled = enabled_nxt;
    if (cmd == CMD_READ || cmd == CMD_READ_PRES) begin
      res.time_ms = cur_time;
    end else begin
      res.time_ms = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      base_r    <= '0;
      high_r    <= '0;
      last_r    <= '0;
    end else if (fire) begin
      enabled_r <= enabled_nxt;
      base_r    <= base_nxt;
      high_r    <= high_nxt;
      last_r    <= last_nxt;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import rtcms_pkg::*;

  // Command codes that the block must ignore: no state change, time_ms of zero.
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam int unsigned IDLE_PCT = 18;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_cmd = '0;
  logic [SAMPLE_W-1:0] in_counter_sample = '0;
  logic [TIME_W-1:0]   in_new_time = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [TIME_W-1:0]   out_time_ms;
  logic                out_clock_enabled;

  // Shadow of the clock state, advanced once per accepted input transfer.
  logic                clk_on;
  logic [TIME_W-1:0]   base_ms;
  logic [SAMPLE_W-1:0] hi_word;
  logic [SAMPLE_W-1:0] last_tick;

  res_t                pending_times[$];
  int unsigned         mismatch_count = 0;
  logic                no_idle = 1'b0;
  logic [SAMPLE_W-1:0] tick_count = '0;

  extended_rtc_millisecond_clock DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_counter_sample (in_counter_sample),
    .in_new_time       (in_new_time),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_time_ms       (out_time_ms),
    .out_clock_enabled (out_clock_enabled)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Convert the widened tick count (hi:lo) to milliseconds. The full product
  // fits in 74 bits, so shift it whole instead of splitting the halves.
  function automatic logic [TIME_W-1:0] ticks_to_ms(input logic [SAMPLE_W-1:0] hi,
                                                    input logic [SAMPLE_W-1:0] lo);
    logic [73:0] prod;
    prod = {10'd0, hi, lo} * 74'd1000;
    return TIME_W'(prod >> TICK_SHIFT);
  endfunction

  // Time as a read would report it; all ones while the clock is off.
  function automatic logic [TIME_W-1:0] clock_now();
    if (!clk_on) return '1;
    return ticks_to_ms(hi_word, last_tick) + base_ms;
  endfunction

  // Advance the shadow state by one command and return the result it yields.
  function automatic res_t predict_clock(input logic [CMD_W-1:0] cmd,
                                         input logic [SAMPLE_W-1:0] sample,
                                         input logic [TIME_W-1:0] new_base);
    res_t r;
    r.time_ms = '0;
    case (cmd)
      CMD_REFRESH, CMD_READ: begin
        // Widen the sample: a sample below the last one means the counter wrapped.
        if (clk_on) begin
          if (sample < last_tick) hi_word = hi_word + 1'b1;
          last_tick = sample;
        end
        if (cmd == CMD_READ) r.time_ms = clock_now();
      end
      CMD_READ_PRES: r.time_ms = clock_now();
      CMD_SET, CMD_RESTORE: begin
        // Restore folds the preserved time into the base; take it before clearing.
        base_ms   = (cmd == CMD_SET) ? new_base : clock_now();
        hi_word   = '0;
        last_tick = '0;
        clk_on    = 1'b1;
      end
      CMD_DISABLE: clk_on = 1'b0;
      default: ;
    endcase
    r.clock_enabled = clk_on;
    return r;
  endfunction

  // Drive one item, hold it until the transfer happens, then queue its expected
  // result. An optional idle gap goes in front so that gaps land on every phase.
  task automatic send_item(input logic [CMD_W-1:0] cmd,
                           input logic [SAMPLE_W-1:0] sample,
                           input logic [TIME_W-1:0] new_base);
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_cmd            <= cmd;
    in_counter_sample <= sample;
    in_new_time       <= new_base;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_times.push_back(predict_clock(cmd, sample, new_base));
  endtask

  // Stall the result channel at random, except during the no-idle stretch.
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare every result transfer with the oldest expectation, field by field.
  always @(posedge clk) begin
    res_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_times.size() == 0) begin
        $error("unexpected result: time_ms %h clock_enabled %b",
               out_time_ms, out_clock_enabled);
        mismatch_count++;
      end else begin
        exp_res = pending_times.pop_front();
        if (out_time_ms !== exp_res.time_ms) begin
          $error("time_ms mismatch: expected %h actual %h", exp_res.time_ms, out_time_ms);
          mismatch_count++;
        end
        if (out_clock_enabled !== exp_res.clock_enabled) begin
          $error("clock_enabled mismatch: expected %b actual %b",
                 exp_res.clock_enabled, out_clock_enabled);
          mismatch_count++;
        end
      end
    end
  end

  // Commands while the clock is off after reset, a restore that turns it on, then the ignored codes.
  task automatic test_disabled_after_reset();
    send_item(CMD_READ, 32'h0000_1234, '1);
    send_item(CMD_REFRESH, 32'hFFFF_FFFF, '0);
    send_item(CMD_READ_PRES, 32'h0, 64'h1);
    // Restore while off: the all-ones preserved time becomes the base.
    send_item(CMD_RESTORE, 32'h0, '0);
    send_item(CMD_READ, 32'h0000_8000, '0);
    send_item(CMD_SPARE_6, 32'hFFFF_FFFF, '1);
    send_item(CMD_SPARE_7, 32'h0, '1);
  endtask

  // Field extremes, counter wrap into the high word and base overflow.
  task automatic test_wrap_and_overflow();
    send_item(CMD_SET, 32'h0, '1);
    send_item(CMD_READ, 32'hFFFF_FFFF, '0);
    send_item(CMD_READ, 32'h0, '0);
    send_item(CMD_READ_PRES, 32'hFFFF_FFFF, '0);
    send_item(CMD_REFRESH, 32'h0000_0005, '0);
    send_item(CMD_READ, 32'h0000_0004, '0);
    send_item(CMD_SET, 32'h0, '0);
    send_item(CMD_READ, 32'h0, '1);
    send_item(CMD_DISABLE, 32'hFFFF_FFFF, '1);
    send_item(CMD_READ, 32'h8000_0000, '0);
    send_item(CMD_READ_PRES, 32'h0, '0);
    send_item(CMD_SET, 32'h0, 64'h5555_5555_5555_5555);
    send_item(CMD_READ, 32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(CMD_RESTORE, 32'h5555_5555, '0);
    send_item(CMD_READ_PRES, 32'h0, '0);
  endtask

  // Mostly refreshes and reads of a running counter with random steps, some
  // of them large enough to wrap; base loads, restores, disables, preserved reads and noise mixed in.
  task automatic test_random_traffic(input int unsigned n_items, input logic calm);
    logic [CMD_W-1:0] cmd;
    int unsigned      pick;
    no_idle = calm;
    repeat (n_items) begin
      case ($urandom_range(0, 9))
        0:       tick_count = $urandom;
        1:       tick_count = tick_count + $urandom_range(0, 3);
        2, 3:    tick_count = tick_count + 32'h8000_0000 + $urandom_range(0, 32'h7FFF_FFFF);
        default: tick_count = tick_count + $urandom_range(1, 70000);
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 40)      cmd = CMD_READ;
      else if (pick < 70) cmd = CMD_REFRESH;
      else if (pick < 78) cmd = CMD_READ_PRES;
      else if (pick < 84) cmd = CMD_SET;
      else if (pick < 89) cmd = CMD_DISABLE;
      else if (pick < 94) cmd = CMD_RESTORE;
      else if (pick < 97) cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
      else                cmd = CMD_W'($urandom);
      send_item(cmd, tick_count, {$urandom, $urandom});
    end
    no_idle = 1'b0;
  endtask

  initial begin
    // Hold reset low, then release it at an edge.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    clk_on    = 1'b0;
    base_ms   = '0;
    hi_word   = '0;
    last_tick = '0;
    @(posedge clk);

    test_disabled_after_reset();
    test_wrap_and_overflow();
    test_random_traffic(550, 1'b0);
    test_random_traffic(250, 1'b1);
    test_random_traffic(550, 1'b0);

    // Drop valid and drain; at most two items are still in the pipeline.
    in_valid <= 1'b0;
    while (pending_times.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Stop a hung run; a correct one needs only a small part of this.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rtcms_pkg.sv
rtl/core/rtcms_ms_calc.sv
rtl/core/rtcms_state.sv
rtl/core/extended_rtc_millisecond_clock.sv
tb/tb_top.sv
